FILE: hw/rtl/tspo_pkg.sv
package tspo_pkg;

  // Converter resolution; full scale follows from it.
  localparam int unsigned ADC_BITS = 12;

  // Fixed field widths of the sample and result transactions.
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned PRESS_W = 16;
  localparam int unsigned PLATE_W = 12;

  // Full scale of the converter, compared with raw x and mirrored against at field width.
  localparam logic [31:0] FULL_SCALE = (32'd1 << ADC_BITS) - 32'd1;

  // Width of diff * x * plate_ohms, kept without wrap.
  localparam int unsigned PROD_W = 2 * FIELD_W + PLATE_W;
  localparam int unsigned DIV_STEPS = PROD_W;

  // Rounding of the quotient down to the pressure scale.
  localparam int unsigned ROUND_SHIFT = 12;
  localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'(2047);
  localparam int unsigned SCALED_W = PROD_W + 1 - ROUND_SHIFT;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_OHMS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LIMIT = 3'd4;

  localparam logic [PLATE_W-1:0] PLATE_RESET = PLATE_W'(700);
  localparam logic [PRESS_W-1:0] LIMIT_RESET = PRESS_W'(3000);

  // Configuration seen by the output stage.
  typedef struct packed {
    logic swap_axes;
    logic mirror_x;
    logic mirror_y;
    logic [PRESS_W-1:0] pressure_limit;
  } tspo_post_cfg_t;

  // Item as it travels down the divider chain.
  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z1;
    logic force_zero;
    logic [FIELD_W-1:0] rem;
    logic [PROD_W-1:0] dq;
  } tspo_div_t;

endpackage

FILE: hw/rtl/tspo_if.sv
// Raw sample channel.
interface tspo_in_if;
  logic valid;
  logic ready;
  logic [tspo_pkg::FIELD_W-1:0] raw_x;
  logic [tspo_pkg::FIELD_W-1:0] raw_y;
  logic [tspo_pkg::FIELD_W-1:0] raw_z1;
  logic [tspo_pkg::FIELD_W-1:0] raw_z2;

  modport source (output valid, raw_x, raw_y, raw_z1, raw_z2, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z1, raw_z2, output ready);
endinterface

// Conditioned result channel.
interface tspo_out_if;
  logic valid;
  logic ready;
  logic [tspo_pkg::FIELD_W-1:0] pos_x;
  logic [tspo_pkg::FIELD_W-1:0] pos_y;
  logic [tspo_pkg::PRESS_W-1:0] pressure;
  logic sample_ok;

  modport source (output valid, pos_x, pos_y, pressure, sample_ok, input ready);
  modport sink (input valid, pos_x, pos_y, pressure, sample_ok, output ready);
endinterface

FILE: hw/rtl/tspo_front.sv
module tspo_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [tspo_pkg::FIELD_W-1:0]    raw_x_i,
  input  logic [tspo_pkg::FIELD_W-1:0]    raw_y_i,
  input  logic [tspo_pkg::FIELD_W-1:0]    raw_z1_i,
  input  logic [tspo_pkg::FIELD_W-1:0]    raw_z2_i,
  input  logic [tspo_pkg::PLATE_W-1:0]    plate_ohms_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output tspo_pkg::tspo_div_t             data_o
);
  import tspo_pkg::*;

  logic [FIELD_W-1:0] x_fix;
  logic [FIELD_W-1:0] diff;

  logic a_valid_q;
  logic a_ready;
  logic [FIELD_W-1:0] a_x_q, a_y_q, a_z1_q;
  logic a_zero_q;
  logic [2*FIELD_W-1:0] a_prod_q;

  logic b_valid_q;
  logic b_ready;
  tspo_div_t b_data_q;

  // A full-scale x reading is invalid and becomes zero; z2 below z1 clamps to zero.
  always_comb begin
    x_fix = (32'(raw_x_i) == FULL_SCALE) ? '0 : raw_x_i;
    diff = (raw_z2_i > raw_z1_i) ? (raw_z2_i - raw_z1_i) : '0;
  end

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // First stage: diff times x.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_x_q    <= x_fix;
      a_y_q    <= raw_y_i;
      a_z1_q   <= raw_z1_i;
      a_zero_q <= (raw_z1_i == '0);
      a_prod_q <= (2*FIELD_W)'(diff) * (2*FIELD_W)'(x_fix);
    end
  end

  // Second stage: times the plate factor, full 36-bit product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_data_q.x          <= a_x_q;
      b_data_q.y          <= a_y_q;
      b_data_q.z1         <= a_z1_q;
      b_data_q.force_zero <= a_zero_q;
      b_data_q.rem        <= '0;
      b_data_q.dq         <= PROD_W'(a_prod_q) * PROD_W'(plate_ohms_i);
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

endmodule

FILE: hw/rtl/tspo_div_cell.sv
module tspo_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tspo_pkg::tspo_div_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tspo_pkg::tspo_div_t data_o
);
  import tspo_pkg::*;

  logic valid_q;
  tspo_div_t data_q;
  tspo_div_t data_d;
  logic [FIELD_W:0] trial;
  logic take;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    trial = {data_i.rem, data_i.dq[PROD_W-1]};
    take = (trial >= {1'b0, data_i.z1});
    data_d = data_i;
    data_d.rem = take ? FIELD_W'(trial - {1'b0, data_i.z1}) : trial[FIELD_W-1:0];
    data_d.dq = {data_i.dq[PROD_W-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/tspo_back.sv
module tspo_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  tspo_pkg::tspo_div_t             data_i,
  input  tspo_pkg::tspo_post_cfg_t        cfg_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [tspo_pkg::FIELD_W-1:0]    pos_x_o,
  output logic [tspo_pkg::FIELD_W-1:0]    pos_y_o,
  output logic [tspo_pkg::PRESS_W-1:0]    pressure_o,
  output logic                            sample_ok_o
);
  import tspo_pkg::*;

  logic [PROD_W:0] rounded;
  logic [SCALED_W-1:0] scaled;
  logic [PRESS_W-1:0] press;
  logic [FIELD_W-1:0] sx, sy, px, py;

  logic valid_q;
  logic [FIELD_W-1:0] pos_x_q, pos_y_q;
  logic [PRESS_W-1:0] press_q;
  logic ok_q;

  // Round the quotient to the pressure scale and saturate; a force_zero item gives zero.
  always_comb begin
    rounded = {1'b0, data_i.dq} + ROUND_ADD;
    scaled = rounded[PROD_W:ROUND_SHIFT];
    if (data_i.force_zero) begin
      press = '0;
    end else if (|scaled[SCALED_W-1:PRESS_W]) begin
      press = '1;
    end else begin
      press = scaled[PRESS_W-1:0];
    end
  end

  // Optional axis swap, then mirroring against full scale.
  always_comb begin
    sx = cfg_i.swap_axes ? data_i.y : data_i.x;
    sy = cfg_i.swap_axes ? data_i.x : data_i.y;
    px = cfg_i.mirror_x ? (FULL_SCALE[FIELD_W-1:0] - sx) : sx;
    py = cfg_i.mirror_y ? (FULL_SCALE[FIELD_W-1:0] - sy) : sy;
  end

  assign ready_o = !valid_q || ready_i;

  // Output register holds a finished transaction until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pos_x_q <= px;
      pos_y_q <= py;
      press_q <= press;
      ok_q    <= (press != '0) && (press < cfg_i.pressure_limit);
    end
  end

  assign valid_o     = valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pressure_o  = press_q;
  assign sample_ok_o = ok_q;

endmodule

FILE: hw/rtl/touch_sample_pressure_orient.sv
// Pipeline: two multiply stages, one divider cell per quotient bit for 36 cells,
// one output register. Throughput: one sample per cycle unless the output stalls;
// every stage holds its own valid bit, so the chain keeps filling while a finished
// result waits at the output.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and loads the
// register defaults: no swap, no mirroring, plate factor 700, limit 3000.
module touch_sample_pressure_orient (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tspo_in_if.sink                           in_if,
  tspo_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [tspo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tspo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tspo_pkg::*;

  logic swap_q, mirror_x_q, mirror_y_q;
  logic [PLATE_W-1:0] plate_q;
  logic [PRESS_W-1:0] limit_q;
  tspo_post_cfg_t post_cfg;

  logic        link_valid [DIV_STEPS+1];
  logic        link_ready [DIV_STEPS+1];
  tspo_div_t   link_data  [DIV_STEPS+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q     <= 1'b0;
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      plate_q    <= PLATE_RESET;
      limit_q    <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SWAP_AXES:   swap_q     <= cfg_data_i[0];
        CFG_MIRROR_X:    mirror_x_q <= cfg_data_i[0];
        CFG_MIRROR_Y:    mirror_y_q <= cfg_data_i[0];
        CFG_PLATE_OHMS:  plate_q    <= cfg_data_i[PLATE_W-1:0];
        CFG_PRESS_LIMIT: limit_q    <= cfg_data_i[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  assign post_cfg = '{swap_axes: swap_q, mirror_x: mirror_x_q, mirror_y: mirror_y_q,
                      pressure_limit: limit_q};

  // Force, clamp and the two multiply stages.
  tspo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_if.valid),
    .ready_o     (in_if.ready),
    .raw_x_i     (in_if.raw_x),
    .raw_y_i     (in_if.raw_y),
    .raw_z1_i    (in_if.raw_z1),
    .raw_z2_i    (in_if.raw_z2),
    .plate_ohms_i(plate_q),
    .valid_o     (link_valid[0]),
    .ready_i     (link_ready[0]),
    .data_o      (link_data[0])
  );

  // Row of division cells, one quotient bit each.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    tspo_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(link_valid[i]),
      .ready_o(link_ready[i]),
      .data_i (link_data[i]),
      .valid_o(link_valid[i+1]),
      .ready_i(link_ready[i+1]),
      .data_o (link_data[i+1])
    );
  end

  // Rounding, saturation, orientation and the output register.
  tspo_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (link_valid[DIV_STEPS]),
    .ready_o    (link_ready[DIV_STEPS]),
    .data_i     (link_data[DIV_STEPS]),
    .cfg_i      (post_cfg),
    .valid_o    (out_if.valid),
    .ready_i    (out_if.ready),
    .pos_x_o    (out_if.pos_x),
    .pos_y_o    (out_if.pos_y),
    .pressure_o (out_if.pressure),
    .sample_ok_o(out_if.sample_ok)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tspo_pkg::*;

  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned TIMEOUT_NS = 4_000_000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;
  localparam logic [FIELD_W-1:0] FS = FULL_SCALE[FIELD_W-1:0];
  localparam logic [FIELD_W-1:0] ADC_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z1;
    logic [FIELD_W-1:0] z2;
  } raw_sample_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [PRESS_W-1:0] pressure;
    logic               sample_ok;
  } touch_result_t;

  typedef enum logic [1:0] {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tspo_in_if  in_ch ();
  tspo_out_if out_ch ();

  touch_sample_pressure_orient dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Copy of the register file as the block should hold it.
  logic               swap_now;
  logic               mirror_x_now;
  logic               mirror_y_now;
  logic [PLATE_W-1:0] plate_now;
  logic [PRESS_W-1:0] limit_now;

  touch_result_t conditioned_q[$];
  int unsigned   error_count = 0;
  int unsigned   report_count = 0;
  int unsigned   burst_left = 0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Expected conditioning of one raw sample under the current registers.
  function automatic touch_result_t condition_sample(raw_sample_t s);
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic [FIELD_W-1:0] held;
    logic [63:0]        diff;
    logic [63:0]        quot;
    logic [PRESS_W-1:0] press;
    touch_result_t      r;
    px = (s.x == FS) ? '0 : s.x;
    py = s.y;
    press = '0;
    if (px != '0 && s.z1 != '0) begin
      // A negative difference clamps to zero; the product never wraps.
      diff = (s.z2 > s.z1) ? 64'(s.z2) - 64'(s.z1) : 64'd0;
      quot = (diff * 64'(px) * 64'(plate_now)) / 64'(s.z1);
      quot = (quot + 64'(ROUND_ADD)) >> ROUND_SHIFT;
      press = (quot > 64'(16'hFFFF)) ? '1 : quot[PRESS_W-1:0];
    end
    if (swap_now) begin
      held = px;
      px = py;
      py = held;
    end
    if (mirror_x_now) px = FS - px;
    if (mirror_y_now) py = FS - py;
    r.pos_x = px;
    r.pos_y = py;
    r.pressure = press;
    r.sample_ok = (press != '0) && (press < limit_now);
    return r;
  endfunction

  // Field value biased toward the ends of the range.
  function automatic logic [FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADC_MAX;
      2: return FIELD_W'($urandom_range(1, 8));
      3: return ADC_MAX - FIELD_W'($urandom_range(1, 8));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Mostly a pressed panel (z2 not below z1), otherwise arbitrary readings.
  function automatic raw_sample_t pick_sample();
    raw_sample_t s;
    s.x = pick_field();
    s.y = pick_field();
    if ($urandom_range(0, 3) != 0) begin
      s.z1 = FIELD_W'($urandom_range(1, 3000));
      s.z2 = s.z1 + FIELD_W'($urandom_range(0, ADC_MAX - s.z1));
    end else begin
      s.z1 = pick_field();
      s.z2 = pick_field();
    end
    return s;
  endfunction

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    error_count++;
    if (report_count < MAX_REPORTS) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
    end
    report_count++;
  endtask

  // Send one sample transaction, opening a new burst after a random gap.
  task automatic send_sample(raw_sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.raw_x  <= s.x;
    in_ch.raw_y  <= s.y;
    in_ch.raw_z1 <= s.z1;
    in_ch.raw_z2 <= s.z2;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    conditioned_q.push_back(condition_sample(s));
  endtask

  // Stop sending and wait until every pending result has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (conditioned_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SWAP_AXES:   swap_now = data[0];
      CFG_MIRROR_X:    mirror_x_now = data[0];
      CFG_MIRROR_Y:    mirror_y_now = data[0];
      CFG_PLATE_OHMS:  plate_now = data[PLATE_W-1:0];
      CFG_PRESS_LIMIT: limit_now = data;
      default: ;
    endcase
  endtask

  // Write all registers; unused upper data bits carry noise.
  task automatic apply_settings(logic swap, logic mx, logic my,
                                logic [PLATE_W-1:0] plate, logic [PRESS_W-1:0] limit);
    write_reg(CFG_SWAP_AXES, {15'($urandom), swap});
    write_reg(CFG_MIRROR_X, {15'($urandom), mx});
    write_reg(CFG_MIRROR_Y, {15'($urandom), my});
    write_reg(CFG_PLATE_OHMS, {4'($urandom), plate});
    write_reg(CFG_PRESS_LIMIT, limit);
  endtask

  // Pressure special cases under the reset register values.
  task automatic test_pressure_cases();
    send_sample(raw_sample_t'{'0, '0, '0, '0});
    send_sample(raw_sample_t'{ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX});
    send_sample(raw_sample_t'{ADC_MAX, 12'd100, 12'd500, 12'd1500});
    send_sample(raw_sample_t'{'0, ADC_MAX, 12'd500, 12'd1500});
    send_sample(raw_sample_t'{12'd2048, 12'd1024, '0, 12'd3000});
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd3000, 12'd1000});
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd1500, 12'd1500});
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd2000, 12'd2100});
    send_sample(raw_sample_t'{ADC_MAX - 1, 12'd1, 12'd1, ADC_MAX});
    send_sample(raw_sample_t'{12'd1, ADC_MAX, ADC_MAX - 1, ADC_MAX});
    // Just below and right at the default limit.
    send_sample(raw_sample_t'{12'd5, 12'd7, 12'd1, 12'd3511});
    send_sample(raw_sample_t'{12'd5, 12'd7, 12'd1, 12'd3512});
  endtask

  // Every combination of swap and the two mirrors.
  task automatic test_orientation();
    logic [2:0] combo;
    for (int i = 0; i < 8; i++) begin
      combo = 3'(i);
      wait_idle();
      apply_settings(combo[2], combo[1], combo[0], PLATE_RESET, LIMIT_RESET);
      if (combo[0]) send_sample(raw_sample_t'{ADC_MAX - 1, '0, 12'd900, 12'd2500});
      else send_sample(raw_sample_t'{'0, ADC_MAX - 1, 12'd900, 12'd2500});
    end
  endtask

  // Zero plate factor, widest plate and limit, zero limit, unused indexes.
  task automatic test_register_extremes();
    wait_idle();
    apply_settings(1'b0, 1'b0, 1'b0, '0, LIMIT_RESET);
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd2000, 12'd3000});
    wait_idle();
    apply_settings(1'b1, 1'b1, 1'b1, '1, '1);
    send_sample(raw_sample_t'{ADC_MAX - 1, 12'd1, 12'd1, ADC_MAX});
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd2000, 12'd2100});
    wait_idle();
    apply_settings(1'b0, 1'b0, 1'b0, PLATE_RESET, '0);
    send_sample(raw_sample_t'{12'd2048, 12'd1024, 12'd2000, 12'd2100});
    wait_idle();
    for (int i = CFG_PRESS_LIMIT + 1; i <= CFG_IDX_TOP; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    send_sample(raw_sample_t'{12'd1500, 12'd2500, 12'd1200, 12'd3900});
  endtask

  // Random samples over a series of random register settings.
  task automatic test_random_traffic();
    logic [PLATE_W-1:0] plate;
    logic [PRESS_W-1:0] limit;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: plate = PLATE_RESET;
        1: plate = '1;
        2: plate = PLATE_W'($urandom_range(1, 16));
        default: plate = PLATE_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: limit = LIMIT_RESET;
        1: limit = '1;
        2: limit = PRESS_W'($urandom_range(0, 512));
        default: limit = PRESS_W'($urandom);
      endcase
      wait_idle();
      apply_settings(1'($urandom), 1'($urandom), 1'($urandom), plate, limit);
      repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
    end
  endtask

  // Result receiver: switches between randomly chosen stall patterns.
  initial begin : result_stall
    rx_mode_e    mode;
    int unsigned mode_left;
    mode = RX_STREAM;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (mode)
        RX_STREAM:  out_ch.ready <= 1'b1;
        RX_MOSTLY:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    out_ch.ready <= mode_left[0];
      endcase
    end
  end

  // Compare each result transaction with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    touch_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (conditioned_q.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          $display("%0t ns: result with nothing pending, actual x=%0d y=%0d p=%0d ok=%0d",
                   $time, out_ch.pos_x, out_ch.pos_y, out_ch.pressure, out_ch.sample_ok);
        end
        report_count++;
      end else begin
        want = conditioned_q.pop_front();
        if (out_ch.pos_x !== want.pos_x) report_field("pos_x", want.pos_x, out_ch.pos_x);
        if (out_ch.pos_y !== want.pos_y) report_field("pos_y", want.pos_y, out_ch.pos_y);
        if (out_ch.pressure !== want.pressure) begin
          report_field("pressure", want.pressure, out_ch.pressure);
        end
        if (out_ch.sample_ok !== want.sample_ok) begin
          report_field("sample_ok", want.sample_ok, out_ch.sample_ok);
        end
      end
    end
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("touch_sample_pressure_orient verification failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    in_ch.raw_z1 = '0;
    in_ch.raw_z2 = '0;
    swap_now = 1'b0;
    mirror_x_now = 1'b0;
    mirror_y_now = 1'b0;
    plate_now = PLATE_RESET;
    limit_now = LIMIT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pressure_cases();
    test_orientation();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("touch_sample_pressure_orient verification clean");
    end else begin
      $display("touch_sample_pressure_orient verification failed");
    end
    $finish;
  end

endmodule

FILE: touch_sample_pressure_orient.f
hw/rtl/tspo_pkg.sv
hw/rtl/tspo_if.sv
hw/rtl/tspo_front.sv
hw/rtl/tspo_div_cell.sv
hw/rtl/tspo_back.sv
hw/rtl/touch_sample_pressure_orient.sv
tb/tb_top.sv
